FILE: design/rsd_pkg.sv
// rsd_pkg: shared types, constants and codes for the repetition segment detector.
// Used by rsd_front, rsd_queue, rsd_div, rsd_back and repetition_segment_detector_top.
`default_nettype none

package rsd_pkg;

    localparam int MAX_SESSION_SAMPLES = 65535;
    localparam int SAMPLES_PER_SECOND  = 25;

    localparam int REP_CAP      = (MAX_SESSION_SAMPLES < 65535) ? MAX_SESSION_SAMPLES : 65535;
    localparam int MIN_DUR_INIT = ((60 * SAMPLES_PER_SECOND) < 65535)
                                  ? (60 * SAMPLES_PER_SECOND) : 65535;

    localparam int ANGLE_W     = 15;
    localparam int DUR_W       = 16;
    localparam int CREDIT_W    = 17;
    localparam int WSUM_W      = 32;
    localparam int ANG_TOT_W   = 30;
    localparam int DUR_TOT_W   = 32;
    localparam int DIVIDEND_W  = 32;
    localparam int DIVISOR_W   = 17;
    localparam int DIV_CNT_W   = 5;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [ANGLE_W-1:0]   ANGLE_INIT      = 15'd23040;
    localparam logic [ANG_TOT_W-1:0] ANGLE_TOTAL_MAX = 30'h3FFF_FFFF;

    localparam logic [14:0] START_THR_RST = 15'd11520;
    localparam logic [14:0] END_THR_RST   = 15'd5120;
    localparam logic [14:0] FULL_THR_RST  = 15'd12800;
    localparam logic [14:0] PART_THR_RST  = 15'd7680;
    localparam logic [15:0] MIN_CRED_RST  = 16'd24;

    typedef enum logic [2:0] {
        CFG_START_THR = 3'd0,
        CFG_END_THR   = 3'd1,
        CFG_FULL_THR  = 3'd2,
        CFG_PART_THR  = 3'd3,
        CFG_MIN_CRED  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [14:0] start_thr;
        logic [14:0] end_thr;
        logic [14:0] full_thr;
        logic [14:0] part_thr;
        logic [15:0] min_credit;
    } cfg_t;

    typedef struct packed {
        logic                counted;
        logic                last;
        logic [DUR_W-1:0]    samples;
        logic [CREDIT_W-1:0] credit;
        logic [WSUM_W-1:0]   wsum;
    } rep_entry_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic [DUR_W-1:0]   rep_count;
        logic [DUR_W-1:0]   mean_duration;
        logic [DUR_W-1:0]   max_duration;
        logic [DUR_W-1:0]   min_duration;
        logic [ANGLE_W-1:0] mean_angle;
        logic [ANGLE_W-1:0] max_angle;
        logic [ANGLE_W-1:0] min_angle;
    } result_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_REP_DIV,
        BK_FIN,
        BK_ANG_DIV,
        BK_DUR_DIV,
        BK_OUT
    } back_state_t;

endpackage

`default_nettype wire

FILE: design/rsd_queue.sv
// rsd_queue: small FIFO of closed-rep words between front and back.
// Depends on rsd_pkg (rep_entry_t).
`default_nettype none

module rsd_queue
    import rsd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire rep_entry_t push_data,
    output logic            full,
    input  wire logic       pop,
    output rep_entry_t      pop_data,
    output logic            empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rep_entry_t      mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem_reg[rd_ptr_reg];
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);

endmodule

`default_nettype wire

FILE: design/rsd_front.sv
// rsd_front: takes samples, tracks the open rep with hysteresis and credit,
// and queues a word for each counted close or session end. Depends on rsd_pkg.
`default_nettype none

module rsd_front
    import rsd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [ANGLE_W-1:0] angle,
    input  wire logic               last,
    input  wire logic               q_full,
    output logic                    push,
    output rep_entry_t              push_data
);

    logic                in_rep_reg, in_rep_next;
    logic [DUR_W-1:0]    samples_reg, samples_next, samples_upd;
    logic [CREDIT_W-1:0] credit_reg, credit_next, credit_upd;
    logic [WSUM_W-1:0]   wsum_reg, wsum_next, wsum_upd;

    logic                accept;
    logic [ANGLE_W-1:0]  limit;
    logic                above;
    logic [1:0]          credit;
    logic [WSUM_W-1:0]   weighted;
    logic                close_fire;
    logic                counted;
    logic [DUR_W-1:0]    close_samples;
    logic [CREDIT_W-1:0] close_credit;
    logic [WSUM_W-1:0]   close_wsum;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        limit = in_rep_reg ? cfg.end_thr : cfg.start_thr;
        above = angle > limit;

        priority if (angle > cfg.full_thr)
        begin
            credit   = 2'd2;
            weighted = {16'd0, angle, 1'b0};
        end
        else if (angle > cfg.part_thr)
        begin
            credit   = 2'd1;
            weighted = {17'd0, angle};
        end
        else
        begin
            credit   = 2'd0;
            weighted = '0;
        end

        if (samples_reg < DUR_W'(REP_CAP))
        begin
            samples_upd = samples_reg + 1'b1;
            credit_upd  = credit_reg + CREDIT_W'(credit);
            wsum_upd    = wsum_reg + weighted;
        end
        else
        begin
            samples_upd = samples_reg;
            credit_upd  = credit_reg;
            wsum_upd    = wsum_reg;
        end

        close_fire    = (!above && in_rep_reg) || (last && above);
        close_samples = above ? samples_upd : samples_reg;
        close_credit  = above ? credit_upd : credit_reg;
        close_wsum    = above ? wsum_upd : wsum_reg;
        counted       = close_fire && (close_credit > {1'b0, cfg.min_credit});

        push              = accept && (last || counted);
        push_data.counted = counted;
        push_data.last    = last;
        push_data.samples = close_samples;
        push_data.credit  = close_credit;
        push_data.wsum    = close_wsum;

        in_rep_next  = in_rep_reg;
        samples_next = samples_reg;
        credit_next  = credit_reg;
        wsum_next    = wsum_reg;
        if (accept)
        begin
            if (close_fire || last)
            begin
                in_rep_next  = 1'b0;
                samples_next = '0;
                credit_next  = '0;
                wsum_next    = '0;
            end
            else if (above)
            begin
                in_rep_next  = 1'b1;
                samples_next = samples_upd;
                credit_next  = credit_upd;
                wsum_next    = wsum_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_rep_reg  <= 1'b0;
            samples_reg <= '0;
            credit_reg  <= '0;
            wsum_reg    <= '0;
        end
        else
        begin
            in_rep_reg  <= in_rep_next;
            samples_reg <= samples_next;
            credit_reg  <= credit_next;
            wsum_reg    <= wsum_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/rsd_div.sv
// rsd_div: restoring divider, one quotient bit per cycle, shared by the back end.
// Depends on rsd_pkg (div_req_t, div_rsp_t).
`default_nettype none

module rsd_div
    import rsd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  qbit;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        qbit  = trial >= {1'b0, dvs_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;

        if (busy_reg)
        begin
            rem_next = qbit ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIVIDEND_W - 1);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

FILE: design/rsd_back.sv
// rsd_back: pops closed-rep words, divides out rep means, keeps session stats
// and drives the result register. Depends on rsd_pkg; uses the top's rsd_div via div_req/div_rsp.
`default_nettype none

module rsd_back
    import rsd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_empty,
    output logic            pop,
    input  wire rep_entry_t entry,
    output div_req_t        div_req,
    input  wire div_rsp_t   div_rsp,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output result_t         m_tdata
);

    back_state_t state_reg, state_next;

    rep_entry_t             ent_reg, ent_next;
    logic [DUR_W-1:0]       count_reg, count_next;
    logic [ANGLE_W-1:0]     min_ang_reg, min_ang_next;
    logic [ANGLE_W-1:0]     max_ang_reg, max_ang_next;
    logic [ANG_TOT_W-1:0]   ang_tot_reg, ang_tot_next;
    logic [DUR_W-1:0]       min_dur_reg, min_dur_next;
    logic [DUR_W-1:0]       max_dur_reg, max_dur_next;
    logic [DUR_TOT_W-1:0]   dur_tot_reg, dur_tot_next;
    logic [ANGLE_W-1:0]     avg_ang_reg, avg_ang_next;
    logic [DUR_W-1:0]       avg_dur_reg, avg_dur_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_data_reg, out_data_next;

    logic [ANGLE_W-1:0]     mean;
    logic [ANG_TOT_W:0]     ang_sum;
    logic [DUR_TOT_W:0]     dur_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        mean    = div_rsp.quotient[ANGLE_W-1:0];
        ang_sum = {1'b0, ang_tot_reg} + (ANG_TOT_W + 1)'(mean);
        dur_sum = {1'b0, dur_tot_reg} + (DUR_TOT_W + 1)'(ent_reg.samples);

        state_next     = state_reg;
        ent_next       = ent_reg;
        count_next     = count_reg;
        min_ang_next   = min_ang_reg;
        max_ang_next   = max_ang_reg;
        ang_tot_next   = ang_tot_reg;
        min_dur_next   = min_dur_reg;
        max_dur_next   = max_dur_reg;
        dur_tot_next   = dur_tot_reg;
        avg_ang_next   = avg_ang_reg;
        avg_dur_next   = avg_dur_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = {DUR_TOT_W'(ang_tot_reg)};
        div_req.divisor  = {1'b0, count_reg};

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop      = 1'b1;
                    ent_next = entry;
                    if (entry.counted)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = entry.wsum;
                        div_req.divisor  = entry.credit;
                        state_next       = BK_REP_DIV;
                    end
                    else
                    begin
                        state_next = BK_FIN;
                    end
                end
            end
            BK_REP_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (count_reg == '0 || mean < min_ang_reg)
                    begin
                        min_ang_next = mean;
                    end
                    if (mean > max_ang_reg)
                    begin
                        max_ang_next = mean;
                    end
                    ang_tot_next = (ang_sum > {1'b0, ANGLE_TOTAL_MAX})
                                   ? ANGLE_TOTAL_MAX : ang_sum[ANG_TOT_W-1:0];
                    if (ent_reg.samples > max_dur_reg)
                    begin
                        max_dur_next = ent_reg.samples;
                    end
                    if (ent_reg.samples < min_dur_reg)
                    begin
                        min_dur_next = ent_reg.samples;
                    end
                    dur_tot_next = dur_sum[DUR_TOT_W] ? '1 : dur_sum[DUR_TOT_W-1:0];
                    if (count_reg != '1)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ent_reg.last ? BK_FIN : BK_IDLE;
                end
            end
            BK_FIN:
            begin
                if (count_reg == '0)
                begin
                    state_next = BK_OUT;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIVIDEND_W'(ang_tot_reg);
                    div_req.divisor  = {1'b0, count_reg};
                    state_next       = BK_ANG_DIV;
                end
            end
            BK_ANG_DIV:
            begin
                if (div_rsp.done)
                begin
                    avg_ang_next     = div_rsp.quotient[ANGLE_W-1:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = dur_tot_reg;
                    div_req.divisor  = {1'b0, count_reg};
                    state_next       = BK_DUR_DIV;
                end
            end
            BK_DUR_DIV:
            begin
                if (div_rsp.done)
                begin
                    avg_dur_next = div_rsp.quotient[DUR_W-1:0];
                    state_next   = BK_OUT;
                end
            end
            BK_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    if (count_reg == '0)
                    begin
                        out_data_next = '0;
                    end
                    else
                    begin
                        out_data_next.min_angle     = min_ang_reg;
                        out_data_next.max_angle     = max_ang_reg;
                        out_data_next.mean_angle    = avg_ang_reg;
                        out_data_next.min_duration  = min_dur_reg;
                        out_data_next.max_duration  = max_dur_reg;
                        out_data_next.mean_duration = avg_dur_reg;
                        out_data_next.rep_count     = count_reg;
                    end
                    count_next   = '0;
                    min_ang_next = ANGLE_INIT;
                    max_ang_next = '0;
                    ang_tot_next = '0;
                    min_dur_next = DUR_W'(MIN_DUR_INIT);
                    max_dur_next = '0;
                    dur_tot_next = '0;
                    state_next   = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            min_ang_reg   <= ANGLE_INIT;
            max_ang_reg   <= '0;
            ang_tot_reg   <= '0;
            min_dur_reg   <= DUR_W'(MIN_DUR_INIT);
            max_dur_reg   <= '0;
            dur_tot_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            min_ang_reg   <= min_ang_next;
            max_ang_reg   <= max_ang_next;
            ang_tot_reg   <= ang_tot_next;
            min_dur_reg   <= min_dur_next;
            max_dur_reg   <= max_dur_next;
            dur_tot_reg   <= dur_tot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg      <= ent_next;
        avg_ang_reg  <= avg_ang_next;
        avg_dur_reg  <= avg_dur_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

FILE: design/repetition_segment_detector_top.sv
// Repetition segment detector top level: config registers, front, queue,
// shared divider and back end. Depends on rsd_pkg and all rsd_* modules.
//
// Usage:
//  - s_axis: one word per joint-angle sample, tdata[14:0] = angle (1/256 deg),
//    tlast marks the final sample of a session.
//  - m_axis: one word per session, sent after the tlast sample.
//  - cfg_we/cfg_index/cfg_data write the threshold registers; write only while idle.
//  - A sample is taken whenever the queue has room. Samples that
//    close no counted rep and carry no tlast leave nothing in the queue.
//  - The back end handles one counted rep at a time (one 32-step divide),
//    so later words wait in the queue while it is busy.
//  - After tlast, m_axis_tvalid follows BK_FIN and BK_OUT for a session with no
//    counted rep, else also the mean angle and mean duration divides, after the
//    rep divide when tlast closes a counted rep and any counted words queued ahead.
//  - Reset clears the session and loads the register defaults.
//  - While m_axis is stalled the result holds in its output register; the
//    back end waits before the next session result, and the front keeps
//    taking samples until the queue fills, then drops s_axis_tready.
`default_nettype none

module repetition_segment_detector_top
    import rsd_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [15:0]  s_axis_tdata,   // [14:0] angle, [15] zero pad
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [14:0] min_angle, [29:15] max_angle, [44:30] mean_angle,
    // [60:45] min_duration, [76:61] max_duration, [92:77] mean_duration,
    // [108:93] rep_count, [111:109] zero pad
    output logic [111:0]      m_axis_tdata,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);

    cfg_t       cfg_reg, cfg_next;
    logic       q_push, q_full, q_pop, q_empty;
    rep_entry_t q_wdata, q_rdata;
    div_req_t   div_req;
    div_rsp_t   div_rsp;
    result_t    result;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_THR: cfg_next.start_thr  = cfg_data[14:0];
                CFG_END_THR:   cfg_next.end_thr    = cfg_data[14:0];
                CFG_FULL_THR:  cfg_next.full_thr   = cfg_data[14:0];
                CFG_PART_THR:  cfg_next.part_thr   = cfg_data[14:0];
                CFG_MIN_CRED:  cfg_next.min_credit = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_thr  <= START_THR_RST;
            cfg_reg.end_thr    <= END_THR_RST;
            cfg_reg.full_thr   <= FULL_THR_RST;
            cfg_reg.part_thr   <= PART_THR_RST;
            cfg_reg.min_credit <= MIN_CRED_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rsd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .angle     (s_axis_tdata[ANGLE_W-1:0]),
        .last      (s_axis_tlast),
        .q_full    (q_full),
        .push      (q_push),
        .push_data (q_wdata)
    );

    rsd_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    rsd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    rsd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .pop      (q_pop),
        .entry    (q_rdata),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (result)
    );

    assign m_axis_tdata = {3'b000, result.rep_count, result.mean_duration,
                           result.max_duration, result.min_duration, result.mean_angle,
                           result.max_angle, result.min_angle};

`ifndef SYNTHESIS
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_div_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> !div_rsp.busy)
        else $error("divider done while still busy");
`endif

endmodule

`default_nettype wire
